// ===== rtl/assert_macros.svh =====
// Assertion macros, used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, held off while reset is asserted.
`define FPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, also during reset.
`define FPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/fpt_pkg.sv =====
// Package for the point tracker update: constants, item type, helpers.
`timescale 1ns / 1ps
`default_nettype none

package fpt_pkg;

    localparam int NUM_POINTS = 1024;
    localparam int FRAC_BITS  = 6;
    localparam int PT_AW      = $clog2(NUM_POINTS);

    localparam int IDX_W   = 10;
    localparam int STEP_W  = 16;
    localparam int POS_W   = 20;
    localparam int DIM_W   = 13;
    localparam int PAR_W   = 16;
    localparam int CSTEP_W = STEP_W + 1;
    localparam int SQ_W    = 2 * STEP_W;
    localparam int WORD_W  = 2 * POS_W + 1;

    localparam int SQ_STAGES  = STEP_W;
    localparam int DIV_STAGES = STEP_W;
    localparam int SQ_TAP     = SQ_STAGES + 1;
    localparam int CLAMP_LAT  = SQ_STAGES + DIV_STAGES + 3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FLOW = 1'b1;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_STEP     = 2'd2;
    localparam logic [1:0] REG_LOST_BORDER  = 2'd3;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         idx;
        logic                     fvalid;
        logic signed [STEP_W-1:0] sx;
        logic signed [STEP_W-1:0] sy;
        logic signed [POS_W-1:0]  lx;
        logic signed [POS_W-1:0]  ly;
    } item_t;

    function automatic logic [STEP_W-1:0] mag16(input logic signed [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        r = s[STEP_W-1] ? STEP_W'(~s + 1'b1) : s;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fpt_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fpt_ram #(
    parameter int AW = 10,
    parameter int DW = 41
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fpt_sqrt.sv =====
// Pipelined integer square root, one result bit per pair of input bits per stage.
`timescale 1ns / 1ps
`default_nettype none

module fpt_sqrt import fpt_pkg::*; (
    input  wire logic              clk,
    input  wire logic              ce,
    input  wire logic [SQ_W-1:0]   radicand,
    output logic      [STEP_W-1:0] root
);

    logic [SQ_W-1:0] n_reg    [SQ_STAGES];
    logic [SQ_W-1:0] root_reg [SQ_STAGES];
    logic [SQ_W-1:0] n_next    [SQ_STAGES];
    logic [SQ_W-1:0] root_next [SQ_STAGES];

    always_comb
    begin
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            logic [SQ_W-1:0] n_in;
            logic [SQ_W-1:0] r_in;
            logic [SQ_W-1:0] b;
            logic [SQ_W:0]   trial;
            n_in  = (k == 0) ? radicand : n_reg[(k == 0) ? 0 : k - 1];
            r_in  = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k - 1];
            b     = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            trial = {1'b0, r_in} + {1'b0, b};
            if ({1'b0, n_in} >= trial)
            begin
                n_next[k]    = n_in - SQ_W'(trial);
                root_next[k] = (r_in >> 1) + b;
            end
            else
            begin
                n_next[k]    = n_in;
                root_next[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                n_reg[k]    <= n_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1][STEP_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/fpt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; quotient known to fit 16 bits.
`timescale 1ns / 1ps
`default_nettype none

module fpt_div import fpt_pkg::*; (
    input  wire logic              clk,
    input  wire logic              ce,
    input  wire logic [SQ_W-1:0]   dividend,
    input  wire logic [STEP_W-1:0] divisor,
    output logic      [STEP_W-1:0] quotient
);

    logic [STEP_W-1:0] r_reg  [DIV_STAGES];
    logic [STEP_W-1:0] lo_reg [DIV_STAGES];
    logic [STEP_W-1:0] d_reg  [DIV_STAGES];
    logic [STEP_W-1:0] r_next  [DIV_STAGES];
    logic [STEP_W-1:0] lo_next [DIV_STAGES];

    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            logic [STEP_W-1:0] r_in;
            logic [STEP_W-1:0] lo_in;
            logic [STEP_W-1:0] d_in;
            logic [STEP_W:0]   t;
            r_in  = (k == 0) ? dividend[SQ_W-1:STEP_W] : r_reg[(k == 0) ? 0 : k - 1];
            lo_in = (k == 0) ? dividend[STEP_W-1:0] : lo_reg[(k == 0) ? 0 : k - 1];
            d_in  = (k == 0) ? divisor : d_reg[(k == 0) ? 0 : k - 1];
            t     = {r_in, lo_in[STEP_W-1]};
            if (t >= {1'b0, d_in})
            begin
                r_next[k]  = STEP_W'(t - {1'b0, d_in});
                lo_next[k] = {lo_in[STEP_W-2:0], 1'b1};
            end
            else
            begin
                r_next[k]  = t[STEP_W-1:0];
                lo_next[k] = {lo_in[STEP_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                r_reg[k]  <= r_next[k];
                lo_reg[k] <= lo_next[k];
                d_reg[k]  <= (k == 0) ? divisor : d_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign quotient = lo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/fpt_clamp.sv =====
// Step length clamp pipeline: squares, compare, square root, scale and divide.
`timescale 1ns / 1ps
`default_nettype none

module fpt_clamp import fpt_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      ce,
    input  wire logic                      in_valid,
    input  wire item_t                     in_item,
    input  wire logic [PAR_W-1:0]          max_step,
    output logic                           out_valid,
    output item_t                          out_item,
    output logic signed [CSTEP_W-1:0]      out_sx,
    output logic signed [CSTEP_W-1:0]      out_sy
);

    item_t           d_reg [CLAMP_LAT];
    logic            v_reg [CLAMP_LAT];
    logic            cl_reg [CLAMP_LAT-2];

    logic [SQ_W-1:0] sqx_reg, sqy_reg, lim_reg, sq_reg;
    logic            clamp_reg;
    logic [SQ_W-1:0] sum_sq;
    logic [STEP_W-1:0] norm, norm_reg, qx, qy;
    logic [SQ_W-1:0] px_reg, py_reg;
    logic [STEP_W-1:0] mx, my, ix, iy;

    assign ix     = mag16(in_item.sx);
    assign iy     = mag16(in_item.sy);
    assign sum_sq = sqx_reg + sqy_reg;
    assign mx     = mag16(d_reg[SQ_TAP].sx);
    assign my     = mag16(d_reg[SQ_TAP].sy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CLAMP_LAT; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < CLAMP_LAT; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d_reg[0] <= in_item;
            for (int k = 1; k < CLAMP_LAT; k++)
            begin
                d_reg[k] <= d_reg[k-1];
            end
            cl_reg[0] <= clamp_reg;
            for (int k = 1; k < CLAMP_LAT - 2; k++)
            begin
                cl_reg[k] <= cl_reg[k-1];
            end
            sqx_reg   <= ix * ix;
            sqy_reg   <= iy * iy;
            lim_reg   <= max_step * max_step;
            sq_reg    <= sum_sq;
            clamp_reg <= (max_step != '0) && (sum_sq > lim_reg);
            px_reg    <= mx * max_step;
            py_reg    <= my * max_step;
            norm_reg  <= norm;
        end
    end

    fpt_sqrt u_sqrt (
        .clk      (clk),
        .ce       (ce),
        .radicand (sq_reg),
        .root     (norm)
    );

    fpt_div u_div_x (
        .clk      (clk),
        .ce       (ce),
        .dividend (px_reg),
        .divisor  (norm_reg),
        .quotient (qx)
    );

    fpt_div u_div_y (
        .clk      (clk),
        .ce       (ce),
        .dividend (py_reg),
        .divisor  (norm_reg),
        .quotient (qy)
    );

    always_comb
    begin
        out_valid = v_reg[CLAMP_LAT-1];
        out_item  = d_reg[CLAMP_LAT-1];
        if (cl_reg[CLAMP_LAT-3])
        begin
            out_sx = out_item.sx[STEP_W-1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            out_sy = out_item.sy[STEP_W-1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        end
        else
        begin
            out_sx = CSTEP_W'(out_item.sx);
            out_sy = CSTEP_W'(out_item.sy);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/flow_point_tracker_update.sv =====
// Top level of the point tracker update: config, point memory, update and output stage.
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | load or flow word
//  m_*     | out | m_tvalid/m_tready  | updated point word
//  cfg_*   | in  | cfg_we             | register writes
//
// One word per cycle sustained unless the output stalls or the clearing pass runs;
// a word passes the clamp path (16-stage square root, 16-stage divider), update
// stage and output register. After reset a clearing pass over all 1024 points
// zeroes the alive flags; s_tready stays low. A stalled output freezes the whole
// pipeline; one memory write per word, with forwarding when consecutive words share a point.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module flow_point_tracker_update import fpt_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // point_index, step_x, step_y, load_x, load_y
    input  wire logic [1:0]  s_tuser,   // command, flow_valid
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_index, pos_x, pos_y
    output logic [1:0]       m_tuser,   // in_image, still_alive
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CNT_W = PT_AW + 1;
    localparam int EXT_W = POS_W + 2;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [PAR_W-1:0] max_step_reg, border_reg;

    logic             ce, in_fire;
    item_t            in_item;
    logic             c_valid;
    item_t            c_item;
    logic signed [CSTEP_W-1:0] c_sx, c_sy;

    logic             w_valid_reg;
    item_t            w_item_reg;
    logic signed [CSTEP_W-1:0] w_sx_reg, w_sy_reg;
    logic             fwd_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic [WORD_W-1:0] ram_q, base, wr_word;

    logic             clr_reg;
    logic [CNT_W-1:0] clr_cnt_reg;

    logic             ram_we;
    logic [PT_AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;

    logic signed [POS_W-1:0] nx, ny;
    logic             alive_n, in_img, lost;
    logic signed [EXT_W-1:0] limx, limy, bext, x22, y22;

    logic             m_valid_reg;
    logic [55:0]      m_data_reg;
    logic [1:0]       m_user_reg;

    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce && !clr_reg;
    assign in_fire  = s_tvalid && s_tready;

    assign in_item.cmd    = s_tuser[0];
    assign in_item.fvalid = s_tuser[1];
    assign in_item.idx    = s_tdata[9:0];
    assign in_item.sx     = s_tdata[25:10];
    assign in_item.sy     = s_tdata[41:26];
    assign in_item.lx     = s_tdata[61:42];
    assign in_item.ly     = s_tdata[81:62];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= DIM_W'(640);
            height_reg   <= DIM_W'(480);
            max_step_reg <= '0;
            border_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg    <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg   <= cfg_data[DIM_W-1:0];
                REG_MAX_STEP:     max_step_reg <= cfg_data;
                REG_LOST_BORDER:  border_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    fpt_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (in_fire),
        .in_item   (in_item),
        .max_step  (max_step_reg),
        .out_valid (c_valid),
        .out_item  (c_item),
        .out_sx    (c_sx),
        .out_sy    (c_sy)
    );

    // clearing pass over the alive flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CNT_W'(NUM_POINTS - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    assign ram_we    = clr_reg || (ce && w_valid_reg);
    assign ram_waddr = clr_reg ? clr_cnt_reg[PT_AW-1:0] : w_item_reg.idx[PT_AW-1:0];
    assign ram_wdata = clr_reg ? '0 : wr_word;

    fpt_ram #(
        .AW (PT_AW),
        .DW (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ce),
        .raddr (c_item.idx[PT_AW-1:0]),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            w_valid_reg <= c_valid;
            fwd_reg     <= w_valid_reg && c_valid && (w_item_reg.idx == c_item.idx);
            m_valid_reg <= w_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            w_item_reg   <= c_item;
            w_sx_reg     <= c_sx;
            w_sy_reg     <= c_sy;
            fwd_data_reg <= wr_word;
            m_data_reg   <= {6'b0, ny, nx, w_item_reg.idx};
            m_user_reg   <= {alive_n, in_img};
        end
    end

    // update stage
    always_comb
    begin
        logic signed [POS_W:0] sum_x, sum_y;
        logic signed [POS_W-1:0] ox, oy;
        base  = fwd_reg ? fwd_data_reg : ram_q;
        ox    = base[POS_W-1:0];
        oy    = base[2*POS_W-1:POS_W];
        sum_x = (POS_W+1)'(ox) + (POS_W+1)'(w_sx_reg);
        sum_y = (POS_W+1)'(oy) + (POS_W+1)'(w_sy_reg);
        limx  = $signed({{(EXT_W-DIM_W-FRAC_BITS){1'b0}}, width_reg,
                         {FRAC_BITS{1'b0}}}) - EXT_W'(1 << FRAC_BITS);
        limy  = $signed({{(EXT_W-DIM_W-FRAC_BITS){1'b0}}, height_reg,
                         {FRAC_BITS{1'b0}}}) - EXT_W'(1 << FRAC_BITS);
        bext  = $signed({{(EXT_W-PAR_W){1'b0}}, border_reg});
        if (w_item_reg.cmd == CMD_LOAD)
        begin
            nx = w_item_reg.lx;
            ny = w_item_reg.ly;
        end
        else if (w_item_reg.fvalid)
        begin
            if (sum_x[POS_W] != sum_x[POS_W-1])
            begin
                nx = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            end
            else
            begin
                nx = sum_x[POS_W-1:0];
            end
            if (sum_y[POS_W] != sum_y[POS_W-1])
            begin
                ny = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            end
            else
            begin
                ny = sum_y[POS_W-1:0];
            end
        end
        else
        begin
            nx = ox;
            ny = oy;
        end
        x22    = EXT_W'(nx);
        y22    = EXT_W'(ny);
        in_img = (x22 >= 0) && (x22 <= limx) && (y22 >= 0) && (y22 <= limy);
        lost   = (x22 + bext < 0) || (x22 > limx + bext) ||
                 (y22 + bext < 0) || (y22 > limy + bext);
        if (w_item_reg.cmd == CMD_LOAD)
        begin
            alive_n = 1'b1;
        end
        else
        begin
            alive_n = base[WORD_W-1] && !lost;
        end
        wr_word = {alive_n, ny, nx};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `FPT_ASSERT(a_no_input_while_clearing, clr_reg |-> !s_tready,
                "input accepted during the clearing pass")
    `FPT_ASSERT(a_fwd_needs_item, fwd_reg |-> w_valid_reg,
                "forwarding flag set with no word in the update stage")
    `FPT_ASSERT(a_clear_length, $fell(clr_reg) |-> clr_cnt_reg == CNT_W'(NUM_POINTS),
                "clearing pass ended early")

endmodule

`default_nettype wire
